@@ sv/rtit_pkg.sv @@
// ----------------------------------------------------------------------------
// rtit_pkg: shared types and constants of the RFID tag inventory table
// Holds the controller/datapath command and status bundles, field widths
// and the EPC character mask helper.
// ----------------------------------------------------------------------------
package rtit_pkg;

  localparam int unsigned EpcWordW = 64;
  localparam int unsigned EpcWords = 3;
  localparam int unsigned KeyW     = EpcWordW * EpcWords;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CntW     = 8;
  localparam int unsigned RssiW    = 8;
  localparam int unsigned RssiOutW = 9;

  localparam logic [CntW-1:0] CntMax = 8'hFF;
  localparam logic [CntW-1:0] CntOne = 8'h01;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the input item
    logic scan_start;  // rewind the table scan
    logic scan_step;   // issue the next read / advance the compare stage
    logic wr_hit;      // update count of the matching entry
    logic wr_miss;     // insert the EPC at the write pointer
    logic load_out;    // move the result into the output register
  } rtit_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tag_read;    // latched item carries a tag read
    logic hit;         // compare stage matches a valid entry
    logic last_miss;   // last entry compared without a match
    logic out_free;    // output register can take a result this cycle
  } rtit_sts_t;

  // Byte mask of the EPC characters of one word that take part in the key
  function automatic logic [EpcWordW-1:0] char_mask(int unsigned word, int unsigned chars);
    logic [EpcWordW-1:0] m;
    m = '0;
    for (int unsigned c = 0; c < 8; c++) begin
      if ((word * 8 + c) < chars) begin
        m[8 * (7 - c) +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ sv/rtit_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtit_ctrl: sequencer of the RFID tag inventory table
// Accepts one item at a time, runs the serial table scan, picks the hit
// or insert update and hands the result to the output register.
// ----------------------------------------------------------------------------
module rtit_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtit_pkg::rtit_sts_t sts_i,
  output rtit_pkg::rtit_cmd_t cmd_o
);
  import rtit_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StHit  = 3'd2;
  localparam logic [2:0] StMiss = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;

  // Take a new item only when idle
  assign in_stall_o = (state_q != StIdle);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch      = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        if (!sts_i.tag_read) begin
          state_d = StDone;
        end else if (sts_i.hit) begin
          state_d = StHit;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.last_miss) begin
            state_d = StMiss;
          end
        end
      end
      StHit: begin
        cmd_o.wr_hit = 1'b1;
        state_d      = StDone;
      end
      StMiss: begin
        cmd_o.wr_miss = 1'b1;
        state_d       = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/rtit_dp.sv @@
// ----------------------------------------------------------------------------
// rtit_dp: datapath of the RFID tag inventory table
// Input holding registers, key and count memories with a registered read
// port, valid bits, write pointer, scan compare stage and output register.
// ----------------------------------------------------------------------------
module rtit_dp #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned EPC_CHARS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rtit_pkg::rtit_cmd_t                 cmd_i,
  output rtit_pkg::rtit_sts_t                 sts_o,
  input  logic                                kind_i,
  input  logic [rtit_pkg::EpcWordW-1:0]       epc_word0_i,
  input  logic [rtit_pkg::EpcWordW-1:0]       epc_word1_i,
  input  logic [rtit_pkg::EpcWordW-1:0]       epc_word2_i,
  input  logic [rtit_pkg::RssiW-1:0]          rssi_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                has_data_o,
  output logic                                is_new_o,
  output logic [rtit_pkg::SlotW-1:0]          slot_o,
  output logic signed [rtit_pkg::RssiOutW-1:0] rssi_o,
  output logic [rtit_pkg::CntW-1:0]           read_count_o,
  output logic [rtit_pkg::EpcWordW-1:0]       epc_out0_o,
  output logic [rtit_pkg::EpcWordW-1:0]       epc_out1_o,
  output logic [rtit_pkg::EpcWordW-1:0]       epc_out2_o
);
  import rtit_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned XW = (IW > SlotW) ? IW : SlotW;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);
  localparam logic [EpcWordW-1:0] Mask0 = char_mask(0, EPC_CHARS);
  localparam logic [EpcWordW-1:0] Mask1 = char_mask(1, EPC_CHARS);
  localparam logic [EpcWordW-1:0] Mask2 = char_mask(2, EPC_CHARS);

  // Input holding registers
  logic                kind_q;
  logic [EpcWordW-1:0] epc0_q, epc1_q, epc2_q;
  logic [RssiW-1:0]    rssi_in_q;
  logic [KeyW-1:0]     key_in;

  // Table storage
  logic [KeyW-1:0]     key_mem [ENTRIES];
  logic [CntW-1:0]     cnt_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [IW-1:0]       wp_q;

  // Scan pipeline
  logic [IW-1:0]       scan_idx_q;
  logic                issue_q;
  logic                cmp_vld_q;
  logic [IW-1:0]       cmp_idx_q;
  logic                cmp_valid_q;
  logic [KeyW-1:0]     key_rd_q;
  logic [CntW-1:0]     cnt_rd_q;
  logic                rd_en;
  logic                hit;

  // Update path
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [CntW-1:0]     wr_cnt;
  logic [IW-1:0]       res_slot_q;
  logic [CntW-1:0]     res_cnt_q;
  logic                res_new_q;
  logic [XW-1:0]       slot_ext;

  // Output register
  logic                out_valid_q;

  // Capture the item at its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
    end else if (cmd_i.latch) begin
      kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      epc0_q    <= epc_word0_i;
      epc1_q    <= epc_word1_i;
      epc2_q    <= epc_word2_i;
      rssi_in_q <= rssi_raw_i;
    end
  end

  // Only the configured EPC characters form the key
  assign key_in = {epc0_q & Mask0, epc1_q & Mask1, epc2_q & Mask2};

  // Scan address, issue flag and compare stage
  assign rd_en = cmd_i.scan_step && issue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      issue_q    <= 1'b1;
      cmp_vld_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_q <= issue_q;
      if (issue_q) begin
        scan_idx_q  <= scan_idx_q + IW'(1);
        issue_q     <= (scan_idx_q != LastIdx);
        cmp_idx_q   <= scan_idx_q;
        cmp_valid_q <= valid_q[scan_idx_q];
      end
    end
  end

  // Match the registered entry against the incoming key
  assign hit = cmp_vld_q && cmp_valid_q && (key_rd_q == key_in);

  // Hit keeps the slot, miss takes the write pointer
  assign wr_en   = cmd_i.wr_hit || cmd_i.wr_miss;
  assign wr_addr = cmd_i.wr_miss ? wp_q : cmp_idx_q;
  assign wr_cnt  = cmd_i.wr_miss ? CntOne :
                   ((cnt_rd_q == CntMax) ? CntMax : cnt_rd_q + CntOne);

  // Table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= key_in;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[scan_idx_q];
      cnt_rd_q <= cnt_mem[scan_idx_q];
    end
  end

  // Valid bits and wrapping write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wp_q    <= '0;
    end else if (cmd_i.wr_miss) begin
      valid_q[wp_q] <= 1'b1;
      wp_q          <= (wp_q == LastIdx) ? '0 : wp_q + IW'(1);
    end
  end

  // Hold the result of the update
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      res_slot_q <= wr_addr;
      res_cnt_q  <= wr_cnt;
      res_new_q  <= cmd_i.wr_miss;
    end
  end

  assign slot_ext = XW'(res_slot_q);

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      has_data_o   <= kind_q;
      is_new_o     <= kind_q && res_new_q;
      slot_o       <= kind_q ? slot_ext[SlotW-1:0] : '0;
      rssi_o       <= kind_q ? {1'b1, rssi_in_q} : '0;
      read_count_o <= kind_q ? res_cnt_q : '0;
      epc_out0_o   <= kind_q ? epc0_q : '0;
      epc_out1_o   <= kind_q ? epc1_q : '0;
      epc_out2_o   <= kind_q ? epc2_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.tag_read  = kind_q;
  assign sts_o.hit       = hit;
  assign sts_o.last_miss = cmp_vld_q && !issue_q && !hit;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

@@ sv/rfid_tag_inventory_table.sv @@
// ----------------------------------------------------------------------------
// rfid_tag_inventory_table: deduplicating inventory of RFID tag reads
// Looks up each tag read by EPC, counts repeat reads of a known tag and
// inserts unknown tags at a wrapping write pointer.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o | kind, epc_word0..2, rssi_raw
//   out      | output    | out_valid_o/out_stall_i | has_data, is_new, slot, rssi,
//            |           |                         | read_count, epc_out0..2
//
// A tag read scans the key memory from entry 0 up to the first hit, or through
// every entry on a miss, and a poll skips the scan. The scan reads one entry per
// cycle through the single registered read port of the key memory.
// Reset clears the valid bits and write pointer at once; no clearing pass.
// A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module rfid_tag_inventory_table #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned EPC_CHARS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [rtit_pkg::EpcWordW-1:0]        epc_word0_i,
  input  logic [rtit_pkg::EpcWordW-1:0]        epc_word1_i,
  input  logic [rtit_pkg::EpcWordW-1:0]        epc_word2_i,
  input  logic [rtit_pkg::RssiW-1:0]           rssi_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 has_data_o,
  output logic                                 is_new_o,
  output logic [rtit_pkg::SlotW-1:0]           slot_o,
  output logic signed [rtit_pkg::RssiOutW-1:0] rssi_o,
  output logic [rtit_pkg::CntW-1:0]            read_count_o,
  output logic [rtit_pkg::EpcWordW-1:0]        epc_out0_o,
  output logic [rtit_pkg::EpcWordW-1:0]        epc_out1_o,
  output logic [rtit_pkg::EpcWordW-1:0]        epc_out2_o
);
  import rtit_pkg::*;

  rtit_cmd_t cmd;
  rtit_sts_t sts;

  // Sequencer
  rtit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table and result datapath
  rtit_dp #(
    .ENTRIES   (ENTRIES),
    .EPC_CHARS (EPC_CHARS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .epc_word0_i  (epc_word0_i),
    .epc_word1_i  (epc_word1_i),
    .epc_word2_i  (epc_word2_i),
    .rssi_raw_i   (rssi_raw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .has_data_o   (has_data_o),
    .is_new_o     (is_new_o),
    .slot_o       (slot_o),
    .rssi_o       (rssi_o),
    .read_count_o (read_count_o),
    .epc_out0_o   (epc_out0_o),
    .epc_out1_o   (epc_out1_o),
    .epc_out2_o   (epc_out2_o)
  );

endmodule

@@ sv/rtit_chk.sv @@
// ----------------------------------------------------------------------------
// rtit_chk: port-level checks of the RFID tag inventory table
// Watches the two channels and the result fields over time; attached to
// the top level by the bind below.
// ----------------------------------------------------------------------------
module rtit_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 has_data_o,
  input logic                                 is_new_o,
  input logic [rtit_pkg::SlotW-1:0]           slot_o,
  input logic signed [rtit_pkg::RssiOutW-1:0] rssi_o,
  input logic [rtit_pkg::CntW-1:0]            read_count_o
);

  // One item at a time: busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) &&
    $stable(read_count_o) && $stable(has_data_o))
    else $error("stalled result changed");

  // Poll result is all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> !is_new_o && slot_o == '0 &&
    rssi_o == '0 && read_count_o == '0)
    else $error("poll result carries data");

  // Tag result has a count and a negative rssi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> read_count_o != '0 && rssi_o[8])
    else $error("tag result has zero count or positive rssi");

  // New entry starts counting at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_new_o |-> has_data_o && read_count_o == 8'd1)
    else $error("new entry count is not one");

endmodule

bind rfid_tag_inventory_table rtit_chk u_rtit_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .has_data_o   (has_data_o),
  .is_new_o     (is_new_o),
  .slot_o       (slot_o),
  .rssi_o       (rssi_o),
  .read_count_o (read_count_o)
);

@@ dv/tb_rfid_tag_inventory_table.sv @@
// ----------------------------------------------------------------------------
// tb_rfid_tag_inventory_table: self-checking bench for the tag inventory table
// Drives polls and tag reads through the valid/stall input channel and
// predicts each result from a local copy of the table (EPC keys, RSSI, read
// counts, valid bits, write pointer). The stimulus covers repeat reads, the
// count ceiling, pointer wrap with overwrites and near-miss EPCs. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rfid_tag_inventory_table;

  localparam int unsigned ENTRIES      = 32;
  localparam int unsigned EPC_CHARS    = 24;
  localparam int unsigned POOL         = 64;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_PRINTS   = 20;

  typedef enum logic {KindPoll = 1'b0, KindRead = 1'b1} item_kind_e;

  typedef struct packed {
    logic                has_data;
    logic                is_new;
    logic [4:0]          slot;
    logic signed [8:0]   rssi;
    logic [7:0]          read_count;
    logic [63:0]         epc0;
    logic [63:0]         epc1;
    logic [63:0]         epc2;
  } tag_result_t;

  // --------------------------------------------------------------------------
  // Inventory predictor and result checker
  // --------------------------------------------------------------------------
  class inventory_scoreboard;
    bit          live[ENTRIES];
    logic [63:0] key0[ENTRIES];
    logic [63:0] key1[ENTRIES];
    logic [63:0] key2[ENTRIES];
    logic [7:0]  signal[ENTRIES];
    logic [7:0]  seen[ENTRIES];
    int unsigned wr_ptr;
    logic [63:0] keep[3];
    tag_result_t expected_q[$];
    int unsigned errors, n_polls, n_inserts, n_repeats, n_overwrites, n_ceiling;

    function new();
      for (int e = 0; e < ENTRIES; e++) live[e] = 1'b0;
      wr_ptr = 0;
      // Keep only the EPC characters that take part in the key
      for (int w = 0; w < 3; w++) begin
        keep[w] = '0;
        for (int c = 0; c < 8; c++) begin
          if (w * 8 + c < EPC_CHARS) keep[w][8 * (7 - c) +: 8] = 8'hFF;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the table for one accepted item and queue its result
    function void note_input(logic kind, logic [63:0] w0, logic [63:0] w1,
                             logic [63:0] w2, logic [7:0] rssi_raw);
      tag_result_t r;
      logic [63:0] k0, k1, k2;
      int          found;
      r = '0;
      if (kind == KindPoll) begin
        n_polls++;
        expected_q.push_back(r);
        return;
      end
      k0 = w0 & keep[0];
      k1 = w1 & keep[1];
      k2 = w2 & keep[2];
      found = -1;
      for (int e = 0; e < ENTRIES; e++) begin
        if (found < 0 && live[e] && key0[e] == k0 && key1[e] == k1 && key2[e] == k2)
          found = e;
      end
      if (found >= 0) begin
        n_repeats++;
        if (seen[found] == 8'hFF) n_ceiling++;
        else seen[found] = seen[found] + 8'd1;
        signal[found] = rssi_raw;
        r.is_new = 1'b0;
      end else begin
        n_inserts++;
        if (live[wr_ptr]) n_overwrites++;
        found = wr_ptr;
        live[found]   = 1'b1;
        key0[found]   = k0;
        key1[found]   = k1;
        key2[found]   = k2;
        signal[found] = rssi_raw;
        seen[found]   = 8'd1;
        wr_ptr = (wr_ptr + 1 >= ENTRIES) ? 0 : wr_ptr + 1;
        r.is_new = 1'b1;
      end
      r.has_data   = 1'b1;
      r.slot       = found[4:0];
      r.rssi       = $signed({1'b1, signal[found]});
      r.read_count = seen[found];
      r.epc0       = w0;
      r.epc1       = w1;
      r.epc2       = w2;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Compare one transferred result with the oldest prediction
    task check_result(tag_result_t got);
      tag_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd0, 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.has_data !== want.has_data)
        report_mismatch("has_data", 64'(got.has_data), 64'(want.has_data));
      if (got.is_new !== want.is_new)
        report_mismatch("is_new", 64'(got.is_new), 64'(want.is_new));
      if (got.slot !== want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
      if (got.rssi !== want.rssi) report_mismatch("rssi", 64'(got.rssi), 64'(want.rssi));
      if (got.read_count !== want.read_count)
        report_mismatch("read_count", 64'(got.read_count), 64'(want.read_count));
      if (got.epc0 !== want.epc0) report_mismatch("epc_out0", got.epc0, want.epc0);
      if (got.epc1 !== want.epc1) report_mismatch("epc_out1", got.epc1, want.epc1);
      if (got.epc2 !== want.epc2) report_mismatch("epc_out2", got.epc2, want.epc2);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        kind_i      = 1'b0;
  logic [63:0] epc_word0_i = '0;
  logic [63:0] epc_word1_i = '0;
  logic [63:0] epc_word2_i = '0;
  logic [7:0]  rssi_raw_i  = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        has_data_o;
  logic        is_new_o;
  logic [4:0]  slot_o;
  logic signed [8:0] rssi_o;
  logic [7:0]  read_count_o;
  logic [63:0] epc_out0_o;
  logic [63:0] epc_out1_o;
  logic [63:0] epc_out2_o;

  bit          idle_en  = 1'b1;
  bit          stall_en = 1'b1;
  int unsigned cycles   = 0;

  inventory_scoreboard sb = new();

  rfid_tag_inventory_table #(
    .ENTRIES   (ENTRIES),
    .EPC_CHARS (EPC_CHARS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .epc_word0_i  (epc_word0_i),
    .epc_word1_i  (epc_word1_i),
    .epc_word2_i  (epc_word2_i),
    .rssi_raw_i   (rssi_raw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .has_data_o   (has_data_o),
    .is_new_o     (is_new_o),
    .slot_o       (slot_o),
    .rssi_o       (rssi_o),
    .read_count_o (read_count_o),
    .epc_out0_o   (epc_out0_o),
    .epc_out1_o   (epc_out1_o),
    .epc_out2_o   (epc_out2_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= stall_en && ($urandom_range(99) < 12);
  end

  // Watch both channels; check results before noting new input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({has_data_o, is_new_o, slot_o, rssi_o, read_count_o,
                         epc_out0_o, epc_out1_o, epc_out2_o});
      if (in_valid_i && !in_stall_o)
        sb.note_input(kind_i, epc_word0_i, epc_word1_i, epc_word2_i, rssi_raw_i);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Hold one item on the input channel until its transfer
  task automatic send_item(item_kind_e kind, logic [191:0] epc, logic [7:0] rssi);
    if (idle_en && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    epc_word0_i <= epc[191:128];
    epc_word1_i <= epc[127:64];
    epc_word2_i <= epc[63:0];
    rssi_raw_i  <= rssi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending until every predicted result has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [191:0] pool[POOL];
    logic [191:0] early[6];
    logic [191:0] key;
    logic [191:0] ones;
    int unsigned  sel, idx, set_size;

    ones = '1;
    for (int p = 0; p < POOL; p++) pool[p] = {rand_word(), rand_word(), rand_word()};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: polls, extreme EPCs and RSSI, repeat reads, one-bit neighbors
    send_item(KindPoll, '0, 8'h00);
    send_item(KindPoll, ones, 8'hFF);
    send_item(KindRead, '0, 8'h00);
    send_item(KindRead, ones, 8'hFF);
    send_item(KindRead, '0, 8'hFF);
    send_item(KindRead, ones, 8'h00);
    send_item(KindRead, ones ^ 192'd1, 8'h80);
    send_item(KindRead, {1'b1, 191'd0}, 8'h7F);
    send_item(KindRead, {"E2003412", "01AB0C00", "1234FFEE"}, 8'hC3);
    send_item(KindRead, {"E2003412", "01AB0C00", "1234FFEE"}, 8'h01);
    send_item(KindPoll, {"E2003412", "01AB0C00", "1234FFEE"}, 8'h55);
    send_item(KindRead, {1'b1, 191'd0}, 8'hFE);
    wait_drained();

    // Drive one tag past the count ceiling
    key = {rand_word(), rand_word(), rand_word()};
    for (int n = 0; n < 262; n++) send_item(KindRead, key, 8'($urandom_range(255)));

    // Fill past the table size so the pointer wraps, then revisit early tags
    for (int n = 0; n < 40; n++) begin
      key = {rand_word(), rand_word(), rand_word()};
      if (n < 6) early[n] = key;
      send_item(KindRead, key, 8'($urandom_range(255)));
    end
    for (int n = 0; n < 6; n++) send_item(KindRead, early[n], 8'($urandom_range(255)));
    wait_drained();

    // Random mix: known tags, one-bit neighbors, unknown tags and polls
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en  = !(n >= 150 && n < 250);
      stall_en = idle_en;
      if (n == 300) wait_drained();
      set_size = (n < 180) ? 24 : ((n < 360) ? 40 : POOL);
      idx = $urandom_range(set_size - 1);
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_item(KindPoll, {rand_word(), rand_word(), rand_word()},
                  8'($urandom_range(255)));
      end else if (sel < 70) begin
        send_item(KindRead, pool[idx], 8'($urandom_range(255)));
      end else if (sel < 85) begin
        key = pool[idx];
        key[$urandom_range(191)] ^= 1'b1;
        send_item(KindRead, key, 8'($urandom_range(255)));
      end else begin
        send_item(KindRead, {rand_word(), rand_word(), rand_word()},
                  8'($urandom_range(255)));
      end
    end

    // Drain and finish
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch("results never delivered", 64'(sb.pending()), 64'd0);
    $display("Run covered %0d polls and %0d tag reads: %0d inserts, %0d repeat reads",
             sb.n_polls, sb.n_inserts + sb.n_repeats, sb.n_inserts, sb.n_repeats);
    $display("  with %0d overwrites of live entries and %0d reads at the count ceiling",
             sb.n_overwrites, sb.n_ceiling);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
